### sv/kop_pkg.sv
// ----------------------------------------------------------------------------
// kop_pkg: shared types and constants for the Kepler orbit position block
// Fixed-point constants, the arctangent table, the controller state and
// command codes, and the structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package kop_pkg;

	localparam int PATH_SEGMENTS = 360;
	localparam int KEPLER_ITERS  = 5;
	localparam int ITER_W        = $clog2(KEPLER_ITERS + 1);

	localparam int ANG_W         = 34;
	localparam int CORDIC_STEPS  = 24;
	localparam int CORDIC_CNT_W  = $clog2(CORDIC_STEPS);
	localparam int DIV_STEPS     = 64;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
	localparam int SQRT_W        = 58;
	localparam int SQRT_STEPS    = 29;
	localparam int SQRT_CNT_W    = $clog2(SQRT_STEPS);
	localparam int PROD_W        = 2 * ANG_W;

	localparam logic signed [ANG_W-1:0] PI_Q28       = 34'sd843314857;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q28   = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q28  = 34'sd421657428;
	localparam logic signed [ANG_W-1:0] CORDIC_K_Q28 = 34'sd163008219;

	localparam logic [31:0] PERIOD_RST   = 32'd65536;
	localparam logic [29:0] DISTANCE_RST = 30'd65536;

	// Register map index (byte address / 4)
	typedef enum logic [2:0] {
		REG_PERIOD   = 3'd0,
		REG_ECC      = 3'd1,
		REG_DISTANCE = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        orbit_period;
		logic [15:0]        ecc;
		logic [29:0]        mean_distance;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RED_CHK, ST_RED_WAIT, ST_MUL_M, ST_DIV_M, ST_DIV_M_WAIT,
		ST_MUL_I, ST_DIV_I, ST_DIV_I_WAIT, ST_SC, ST_SC_WAIT, ST_MUL_K, ST_E_UPD,
		ST_MUL_EE, ST_SQ, ST_SQ_WAIT, ST_MUL_X, ST_X_TAKE, ST_MUL_S, ST_MUL_Z,
		ST_Z_TAKE, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_DIV_RED, CMD_RED_TAKE, CMD_MUL_M, CMD_DIV_PROD,
		CMD_M_TAKE, CMD_MUL_I, CMD_I_TAKE, CMD_SC_START, CMD_MUL_K, CMD_E_TAKE,
		CMD_MUL_EE, CMD_SQ_START, CMD_MUL_X, CMD_X_TAKE, CMD_MUL_S, CMD_MUL_Z,
		CMD_Z_TAKE, CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic red_need;
		logic div_done;
		logic cor_done;
		logic sq_done;
		logic out_free;
	} stat_t;

	// CORDIC arctangent of 2^-i in Q28
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [CORDIC_CNT_W-1:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			5'd0:    r = 34'sd210828714;
			5'd1:    r = 34'sd124459457;
			5'd2:    r = 34'sd65760959;
			5'd3:    r = 34'sd33381290;
			5'd4:    r = 34'sd16755422;
			5'd5:    r = 34'sd8385879;
			5'd6:    r = 34'sd4193963;
			5'd7:    r = 34'sd2097109;
			5'd8:    r = 34'sd1048571;
			5'd9:    r = 34'sd524287;
			default: r = 34'sd1 <<< (5'd28 - i);
		endcase
		return r;
	endfunction

	// Clamp a wide signed sum to the int32 range
	function automatic logic [31:0] sat32(input logic signed [40:0] v);
		logic [31:0] r;
		if (v > 41'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -41'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### sv/kop_div.sv
// ----------------------------------------------------------------------------
// kop_div: restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle; gives the
// quotient and the remainder and pulses done after the last step.
// ----------------------------------------------------------------------------
module kop_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [31:0] remainder
);

	logic                          busy_q;
	logic                          done_q;
	logic [kop_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [32:0]                   rem_q;
	logic [63:0]                   quo_q;
	logic [31:0]                   dvs_q;
	logic [32:0]                   shifted;
	logic                          fits;

	// Trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q[31:0], quo_q[63]};
	assign fits    = shifted >= {1'b0, dvs_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kop_pkg::DIV_CNT_W'(kop_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[31:0];

endmodule

### sv/kop_cordic.sv
// ----------------------------------------------------------------------------
// kop_cordic: iterative sine and cosine
// Folds the angle into [-pi/2, pi/2], then runs the rotation-mode CORDIC
// one micro-rotation per cycle in Q28.
// ----------------------------------------------------------------------------
module kop_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [kop_pkg::ANG_W-1:0]    ang,
	output logic                                done,
	output logic signed [kop_pkg::ANG_W-1:0]    sin_val,
	output logic signed [kop_pkg::ANG_W-1:0]    cos_val
);

	logic                                busy_q;
	logic                                done_q;
	logic                                flip_q;
	logic [kop_pkg::CORDIC_CNT_W-1:0]    i_q;
	logic signed [kop_pkg::ANG_W-1:0]    x_q, y_q, z_q;
	logic signed [kop_pkg::ANG_W-1:0]    wrapped, folded;
	logic                                flip;
	logic signed [kop_pkg::ANG_W-1:0]    dx, dy, da;

	// Wrap into [-pi, pi], then mirror into the right half plane
	always_comb begin
		if (ang > kop_pkg::PI_Q28) begin
			wrapped = ang - kop_pkg::TWO_PI_Q28;
		end else if (ang < -kop_pkg::PI_Q28) begin
			wrapped = ang + kop_pkg::TWO_PI_Q28;
		end else begin
			wrapped = ang;
		end
		if (wrapped > kop_pkg::HALF_PI_Q28) begin
			folded = kop_pkg::PI_Q28 - wrapped;
			flip   = 1'b1;
		end else if (wrapped < -kop_pkg::HALF_PI_Q28) begin
			folded = -kop_pkg::PI_Q28 - wrapped;
			flip   = 1'b1;
		end else begin
			folded = wrapped;
			flip   = 1'b0;
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign da = kop_pkg::atan_step(i_q);

	// Sequence the micro-rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == kop_pkg::CORDIC_CNT_W'(kop_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Rotate towards zero residual angle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= kop_pkg::CORDIC_K_Q28;
			y_q    <= '0;
			z_q    <= folded;
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[kop_pkg::ANG_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	assign done    = done_q;
	assign sin_val = y_q;
	assign cos_val = flip_q ? -x_q : x_q;

endmodule

### sv/kop_dp.sv
// ----------------------------------------------------------------------------
// kop_dp: datapath of the orbit position block
// Holds elapsed time and working values, the shared multiplier, the
// divider, the CORDIC unit, the square root unit and the output register.
// ----------------------------------------------------------------------------
module kop_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kop_pkg::cfg_t        cfg,
	input  kop_pkg::cmd_t        cmd,
	output kop_pkg::stat_t       stat,
	input  logic [31:0]          delta_time,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [111:0]         m_tdata
);

	localparam int AW = kop_pkg::ANG_W;
	localparam int PW = kop_pkg::PROD_W;

	logic [31:0]                  elapsed_q;
	logic [32:0]                  t_q;
	logic signed [AW-1:0]         m_q, e_q;
	logic [8:0]                   idx_q;
	logic signed [PW-1:0]         prod_q;
	logic [31:0]                  x_sat_q, z_sat_q;
	logic                         out_valid_q;
	logic [111:0]                 out_q;
	logic [31:0]                  per_eff;

	logic signed [AW-1:0]         mul_a, mul_b;
	logic [63:0]                  div_dvd;
	logic                         div_start, div_done;
	logic [63:0]                  div_quo;
	logic [31:0]                  div_rem;
	logic                         cor_done;
	logic signed [AW-1:0]         sin_v, cos_v;

	logic [kop_pkg::SQRT_W-1:0]     sq_v_q, sq_res_q, sq_bit_q, sq_try;
	logic [kop_pkg::SQRT_CNT_W-1:0] sq_cnt_q;
	logic                           sq_busy_q, sq_done_q;
	logic [32:0]                    one_minus_ee;

	logic signed [40:0]           x_sum, z_sum;

	// A zero period counts as one
	assign per_eff = (cfg.orbit_period == 32'd0) ? 32'd1 : cfg.orbit_period;

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd)
			kop_pkg::CMD_MUL_M: begin
				mul_a = AW'($signed({1'b0, t_q}));
				mul_b = kop_pkg::TWO_PI_Q28;
			end
			kop_pkg::CMD_MUL_I: begin
				mul_a = AW'($signed({1'b0, t_q}));
				mul_b = AW'(kop_pkg::PATH_SEGMENTS + 1);
			end
			kop_pkg::CMD_MUL_K: begin
				mul_a = AW'($signed({1'b0, cfg.ecc}));
				mul_b = sin_v;
			end
			kop_pkg::CMD_MUL_EE: begin
				mul_a = AW'($signed({1'b0, cfg.ecc}));
				mul_b = AW'($signed({1'b0, cfg.ecc}));
			end
			kop_pkg::CMD_MUL_X: begin
				mul_a = AW'($signed({1'b0, cfg.mean_distance}));
				mul_b = cos_v - AW'($signed({1'b0, cfg.ecc, 12'd0}));
			end
			kop_pkg::CMD_MUL_S: begin
				mul_a = sin_v;
				mul_b = AW'($signed({1'b0, sq_res_q[28:0]}));
			end
			kop_pkg::CMD_MUL_Z: begin
				mul_a = AW'($signed({1'b0, cfg.mean_distance}));
				mul_b = prod_q[61:28];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Register each product
	always_ff @(posedge clk) begin
		case (cmd)
			kop_pkg::CMD_MUL_M, kop_pkg::CMD_MUL_I, kop_pkg::CMD_MUL_K,
			kop_pkg::CMD_MUL_EE, kop_pkg::CMD_MUL_X, kop_pkg::CMD_MUL_S,
			kop_pkg::CMD_MUL_Z: prod_q <= mul_a * mul_b;
			default: prod_q <= prod_q;
		endcase
	end

	// Divider: period reduction, mean anomaly and path index
	assign div_start = (cmd == kop_pkg::CMD_DIV_RED) || (cmd == kop_pkg::CMD_DIV_PROD);
	assign div_dvd   = (cmd == kop_pkg::CMD_DIV_RED) ? {31'd0, t_q} : prod_q[63:0];

	kop_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (per_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	kop_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd == kop_pkg::CMD_SC_START),
		.ang     (e_q),
		.done    (cor_done),
		.sin_val (sin_v),
		.cos_val (cos_v)
	);

	// Square root of (1 - e^2) scaled to Q28, two radicand bits a step
	assign one_minus_ee = 33'h1_0000_0000 - prod_q[32:0];
	assign sq_try       = sq_res_q + sq_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd == kop_pkg::CMD_SQ_START) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= '0;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
				if (sq_cnt_q == kop_pkg::SQRT_CNT_W'(kop_pkg::SQRT_STEPS - 1)) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == kop_pkg::CMD_SQ_START) begin
			sq_v_q   <= {1'b0, one_minus_ee, 24'd0};
			sq_res_q <= '0;
			sq_bit_q <= kop_pkg::SQRT_W'(1) << 56;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_try) begin
				sq_v_q   <= sq_v_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// Offset by the centre and clamp
	assign x_sum = 41'($signed(cfg.center_x)) + 41'($signed(prod_q[67:28]));
	assign z_sum = 41'($signed(cfg.center_z)) + 41'($signed(prod_q[67:28]));

	// Hold elapsed time across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (cmd == kop_pkg::CMD_MUL_M) begin
			elapsed_q <= t_q[31:0];
		end
	end

	// Working values
	always_ff @(posedge clk) begin
		case (cmd)
			kop_pkg::CMD_LOAD:     t_q <= {1'b0, elapsed_q} + {1'b0, delta_time};
			kop_pkg::CMD_RED_TAKE: t_q <= {1'b0, div_rem};
			kop_pkg::CMD_M_TAKE: begin
				m_q <= AW'($signed({1'b0, div_quo[31:0]}));
				e_q <= AW'($signed({1'b0, div_quo[31:0]}));
			end
			kop_pkg::CMD_I_TAKE: begin
				idx_q <= (div_quo > 64'(kop_pkg::PATH_SEGMENTS)) ?
					9'(kop_pkg::PATH_SEGMENTS) : div_quo[8:0];
			end
			kop_pkg::CMD_E_TAKE: e_q     <= m_q + prod_q[49:16];
			kop_pkg::CMD_X_TAKE: x_sat_q <= kop_pkg::sat32(x_sum);
			kop_pkg::CMD_Z_TAKE: z_sat_q <= kop_pkg::sat32(z_sum);
			default: t_q <= t_q;
		endcase
	end

	// Output register: fill on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == kop_pkg::CMD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == kop_pkg::CMD_OUT) begin
			out_q <= {7'd0, idx_q, z_sat_q, cfg.center_y, x_sat_q};
		end
	end

	assign stat.red_need = t_q > {1'b0, per_eff};
	assign stat.div_done = div_done;
	assign stat.cor_done = cor_done;
	assign stat.sq_done  = sq_done_q;
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### sv/kop_ctrl.sv
// ----------------------------------------------------------------------------
// kop_ctrl: sequencer of the orbit position block
// Steps the datapath through period reduction, mean anomaly, path index,
// the Kepler iterations and the final position.
// ----------------------------------------------------------------------------
module kop_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  kop_pkg::stat_t   stat,
	output kop_pkg::cmd_t    cmd
);

	kop_pkg::state_t             state_q, state_d;
	logic [kop_pkg::ITER_W-1:0]  iter_q;
	logic                        last_iter;

	assign last_iter = iter_q == kop_pkg::ITER_W'(kop_pkg::KEPLER_ITERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kop_pkg::ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd == kop_pkg::CMD_M_TAKE) begin
				iter_q <= '0;
			end else if (cmd == kop_pkg::CMD_E_TAKE) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kop_pkg::ST_IDLE:       if (s_tvalid) state_d = kop_pkg::ST_RED_CHK;
			kop_pkg::ST_RED_CHK:    state_d = stat.red_need ? kop_pkg::ST_RED_WAIT
			                                                : kop_pkg::ST_MUL_M;
			kop_pkg::ST_RED_WAIT:   if (stat.div_done) state_d = kop_pkg::ST_MUL_M;
			kop_pkg::ST_MUL_M:      state_d = kop_pkg::ST_DIV_M;
			kop_pkg::ST_DIV_M:      state_d = kop_pkg::ST_DIV_M_WAIT;
			kop_pkg::ST_DIV_M_WAIT: if (stat.div_done) state_d = kop_pkg::ST_MUL_I;
			kop_pkg::ST_MUL_I:      state_d = kop_pkg::ST_DIV_I;
			kop_pkg::ST_DIV_I:      state_d = kop_pkg::ST_DIV_I_WAIT;
			kop_pkg::ST_DIV_I_WAIT: if (stat.div_done) state_d = kop_pkg::ST_SC;
			kop_pkg::ST_SC:         state_d = kop_pkg::ST_SC_WAIT;
			kop_pkg::ST_SC_WAIT: begin
				if (stat.cor_done) begin
					state_d = last_iter ? kop_pkg::ST_MUL_EE : kop_pkg::ST_MUL_K;
				end
			end
			kop_pkg::ST_MUL_K:      state_d = kop_pkg::ST_E_UPD;
			kop_pkg::ST_E_UPD:      state_d = kop_pkg::ST_SC;
			kop_pkg::ST_MUL_EE:     state_d = kop_pkg::ST_SQ;
			kop_pkg::ST_SQ:         state_d = kop_pkg::ST_SQ_WAIT;
			kop_pkg::ST_SQ_WAIT:    if (stat.sq_done) state_d = kop_pkg::ST_MUL_X;
			kop_pkg::ST_MUL_X:      state_d = kop_pkg::ST_X_TAKE;
			kop_pkg::ST_X_TAKE:     state_d = kop_pkg::ST_MUL_S;
			kop_pkg::ST_MUL_S:      state_d = kop_pkg::ST_MUL_Z;
			kop_pkg::ST_MUL_Z:      state_d = kop_pkg::ST_Z_TAKE;
			kop_pkg::ST_Z_TAKE:     state_d = kop_pkg::ST_OUT;
			kop_pkg::ST_OUT:        if (stat.out_free) state_d = kop_pkg::ST_IDLE;
			default:                state_d = kop_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = kop_pkg::CMD_NONE;
		s_tready = 1'b0;
		case (state_q)
			kop_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd = kop_pkg::CMD_LOAD;
			end
			kop_pkg::ST_RED_CHK:    if (stat.red_need) cmd = kop_pkg::CMD_DIV_RED;
			kop_pkg::ST_RED_WAIT:   if (stat.div_done) cmd = kop_pkg::CMD_RED_TAKE;
			kop_pkg::ST_MUL_M:      cmd = kop_pkg::CMD_MUL_M;
			kop_pkg::ST_DIV_M:      cmd = kop_pkg::CMD_DIV_PROD;
			kop_pkg::ST_DIV_M_WAIT: if (stat.div_done) cmd = kop_pkg::CMD_M_TAKE;
			kop_pkg::ST_MUL_I:      cmd = kop_pkg::CMD_MUL_I;
			kop_pkg::ST_DIV_I:      cmd = kop_pkg::CMD_DIV_PROD;
			kop_pkg::ST_DIV_I_WAIT: if (stat.div_done) cmd = kop_pkg::CMD_I_TAKE;
			kop_pkg::ST_SC:         cmd = kop_pkg::CMD_SC_START;
			kop_pkg::ST_MUL_K:      cmd = kop_pkg::CMD_MUL_K;
			kop_pkg::ST_E_UPD:      cmd = kop_pkg::CMD_E_TAKE;
			kop_pkg::ST_MUL_EE:     cmd = kop_pkg::CMD_MUL_EE;
			kop_pkg::ST_SQ:         cmd = kop_pkg::CMD_SQ_START;
			kop_pkg::ST_MUL_X:      cmd = kop_pkg::CMD_MUL_X;
			kop_pkg::ST_X_TAKE:     cmd = kop_pkg::CMD_X_TAKE;
			kop_pkg::ST_MUL_S:      cmd = kop_pkg::CMD_MUL_S;
			kop_pkg::ST_MUL_Z:      cmd = kop_pkg::CMD_MUL_Z;
			kop_pkg::ST_Z_TAKE:     cmd = kop_pkg::CMD_Z_TAKE;
			kop_pkg::ST_OUT:        if (stat.out_free) cmd = kop_pkg::CMD_OUT;
			default:                cmd = kop_pkg::CMD_NONE;
		endcase
	end

endmodule

### sv/kepler_orbit_position_top.sv
// ----------------------------------------------------------------------------
// kepler_orbit_position_top: orbit position from accumulated time steps
// Sequence: two divider runs per item, three when the elapsed time passes
//   the period, and six 24-step CORDIC passes through shared units.
// Throughput: one item at a time; the next item is accepted the cycle after
//   the result enters the output register.
// Reset: clears elapsed time and state; registers return to period 1.0,
//   distance 1.0, eccentricity and centre 0.
// ----------------------------------------------------------------------------
module kepler_orbit_position_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // [31:0] delta_time
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
	                                 // [104:96] path_index, [111:105] zero
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	kop_pkg::cfg_t    cfg_q;
	kop_pkg::cmd_t    cmd;
	kop_pkg::stat_t   stat;
	kop_pkg::reg_idx_t reg_idx;
	logic             wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = kop_pkg::reg_idx_t'(paddr[4:2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orbit_period  <= kop_pkg::PERIOD_RST;
			cfg_q.ecc           <= '0;
			cfg_q.mean_distance <= kop_pkg::DISTANCE_RST;
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.center_z      <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				kop_pkg::REG_PERIOD:   cfg_q.orbit_period  <= pwdata;
				kop_pkg::REG_ECC:      cfg_q.ecc           <= pwdata[15:0];
				kop_pkg::REG_DISTANCE: cfg_q.mean_distance <= pwdata[29:0];
				kop_pkg::REG_CENTER_X: cfg_q.center_x      <= pwdata;
				kop_pkg::REG_CENTER_Y: cfg_q.center_y      <= pwdata;
				kop_pkg::REG_CENTER_Z: cfg_q.center_z      <= pwdata;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			kop_pkg::REG_PERIOD:   prdata = cfg_q.orbit_period;
			kop_pkg::REG_ECC:      prdata = {16'd0, cfg_q.ecc};
			kop_pkg::REG_DISTANCE: prdata = {2'd0, cfg_q.mean_distance};
			kop_pkg::REG_CENTER_X: prdata = cfg_q.center_x;
			kop_pkg::REG_CENTER_Y: prdata = cfg_q.center_y;
			kop_pkg::REG_CENTER_Z: prdata = cfg_q.center_z;
			default:               prdata = '0;
		endcase
	end

	kop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kop_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.stat       (stat),
		.delta_time (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

### verif/tb_kepler_orbit_position_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kepler_orbit_position_top: self-checking bench for the orbit position block
// Drives time steps in bursts while the result side stalls on its own pattern.
// A scoreboard class predicts each position from its own fixed-point copy of
// the orbit and the configuration, and compares every result field by field.
// Register settings change between phases, including the extremes.
// ----------------------------------------------------------------------------
module tb_kepler_orbit_position_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 450;

	typedef struct packed {
		logic [8:0]  path_index;
		logic [31:0] pos_z;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} orbit_pos_t;

	// Orbit scoreboard: mirrors the registers and elapsed time, holds expected positions
	class orbit_scoreboard;
		localparam longint ANG_PI     = 843314857;
		localparam longint ANG_TWO_PI = 1686629713;
		localparam longint ANG_HALF   = 421657428;
		localparam longint GAIN_START = 163008219;

		bit [31:0]   period;
		bit [15:0]   ecc;
		bit [29:0]   distance;
		bit [31:0]   cen_x, cen_y, cen_z;
		bit [31:0]   elapsed;
		orbit_pos_t  pending_pos[$];
		int          errors;
		longint      atan_tab[10];

		function new();
			atan_tab = '{210828714, 124459457, 65760959, 33381290, 16755422,
				8385879, 4193963, 2097109, 1048571, 524287};
			period   = 32'd65536;
			ecc      = '0;
			distance = 30'd65536;
			cen_x    = '0;
			cen_y    = '0;
			cen_z    = '0;
			elapsed  = '0;
			errors   = 0;
		endfunction

		function void set_reg(kop_pkg::reg_idx_t r, bit [31:0] v);
			case (r)
				kop_pkg::REG_PERIOD:   period = v;
				kop_pkg::REG_ECC:      ecc = v[15:0];
				kop_pkg::REG_DISTANCE: distance = v[29:0];
				kop_pkg::REG_CENTER_X: cen_x = v;
				kop_pkg::REG_CENTER_Y: cen_y = v;
				kop_pkg::REG_CENTER_Z: cen_z = v;
				default: ;
			endcase
		endfunction

		// Rotate a gain-compensated vector through the folded angle
		function void rotate(input longint ang, output longint s, output longint c);
			longint x, y, z, dx, dy, step;
			bit     flip;
			x = GAIN_START;
			y = 0;
			flip = 0;
			while (ang > ANG_PI) ang -= ANG_TWO_PI;
			while (ang < -ANG_PI) ang += ANG_TWO_PI;
			if (ang > ANG_HALF) begin
				ang = ANG_PI - ang;
				flip = 1;
			end else if (ang < -ANG_HALF) begin
				ang = -ANG_PI - ang;
				flip = 1;
			end
			z = ang;
			for (int i = 0; i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				step = (i < 10) ? atan_tab[i] : (longint'(1) << (28 - i));
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= step;
				end else begin
					x += dx;
					y -= dy;
					z += step;
				end
			end
			s = y;
			c = flip ? -x : x;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function bit [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'h7fff_ffff;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return v[31:0];
		endfunction

		// Advance elapsed time by one step and queue the position it gives
		function void note_step(bit [31:0] delta);
			longint unsigned per, t, idx, ee;
			longint m, e, s, c, sq, s2, x, z, a, ev;
			orbit_pos_t p;
			per = (period == 0) ? 64'd1 : {32'd0, period};
			t = {32'd0, elapsed} + {32'd0, delta};
			if (t > per) t = t % per;
			elapsed = t[31:0];
			m = longint'((t * 64'd1686629713) / per);
			ev = longint'({48'd0, ecc});
			a = longint'({34'd0, distance});
			e = m;
			for (int i = 0; i < 5; i++) begin
				rotate(e, s, c);
				e = m + ((ev * s) >>> 16);
			end
			rotate(e, s, c);
			ee = {48'd0, ecc};
			sq = longint'(root(((64'd1 << 32) - ee * ee) << 24));
			x = (a * (c - (ev << 12))) >>> 28;
			s2 = (s * sq) >>> 28;
			z = (a * s2) >>> 28;
			idx = (t * 64'd361) / per;
			if (idx > 64'd360) idx = 64'd360;
			p.pos_x = clamp32(longint'(signed'(cen_x)) + x);
			p.pos_y = cen_y;
			p.pos_z = clamp32(longint'(signed'(cen_z)) + z);
			p.path_index = idx[8:0];
			pending_pos = {pending_pos, p};
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch %s: got %h want %h", what, got, want);
		endtask

		task check_result(logic [111:0] data);
			orbit_pos_t want;
			if (pending_pos.size() == 0) begin
				report("unexpected result", data[31:0], 32'd0);
				return;
			end
			want = pending_pos.pop_front();
			if (data[31:0] !== want.pos_x) report("pos_x", data[31:0], want.pos_x);
			if (data[63:32] !== want.pos_y) report("pos_y", data[63:32], want.pos_y);
			if (data[95:64] !== want.pos_z) report("pos_z", data[95:64], want.pos_z);
			if (data[104:96] !== want.path_index)
				report("path_index", {23'd0, data[104:96]}, {23'd0, want.path_index});
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [31:0]   s_tdata;   // [31:0] delta_time
	logic          m_tvalid;
	logic          m_tready;
	logic [111:0]  m_tdata;   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
	                          // [104:96] path_index, [111:105] zero
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [4:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	orbit_scoreboard sb;
	int              idle_cycles;
	int              burst_left;

	kepler_orbit_position_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Write one register through a setup and an access cycle
	task apb_write(kop_pkg::reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {r, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(r, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Send one time step; start a new burst after a random gap when one runs out
	task send_step(logic [31:0] delta);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid = 1'b1;
		s_tdata = delta;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_step(delta);
		burst_left--;
	endtask

	task finish_sending();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_pos.size() != 0) @(posedge clk);
	endtask

	function logic [31:0] pick_delta(logic [31:0] per);
		case ($urandom_range(0, 9))
			0, 1, 2:    return $urandom;
			3, 4:       return $urandom_range(0, 15);
			default:    return $urandom_range(0, (per == 0) ? 1 : per);
		endcase
	endfunction

	function logic [31:0] pick_period();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(1, 1000);
			1:       return 32'd65536;
			2:       return 32'hffff_ffff;
			3:       return $urandom_range(32'h1_0000, 32'h10_0000);
			default: return $urandom;
		endcase
	endfunction

	// Result side: check at the rising edge, pick the stall pattern at the falling edge
	initial begin
		int stall_left;
		int calm;
		stall_left = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			@(negedge clk);
			if (calm > 0) begin
				calm--;
				m_tready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
				case ($urandom_range(0, 199))
					0:       calm = $urandom_range(500, 3000);
					1, 2, 3: stall_left = $urandom_range(1, 12);
					default: ;
				endcase
			end
		end
	end

	// Watchdog: end the run after too long without any handshake or bus select
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] per;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero step, time equal to period, huge step
		send_step(32'd0);
		send_step(32'd65536);
		send_step(32'd0);
		send_step(32'hffff_ffff);
		send_step(32'd32768);
		send_step(32'd1);
		send_step(32'h8000_0000);
		finish_sending();

		// Zero period is taken as one
		apb_write(kop_pkg::REG_PERIOD, 32'd0);
		send_step(32'd0);
		send_step(32'd1);
		send_step(32'd5);
		finish_sending();

		// Extremes: full period, largest eccentricity, saturating centre
		apb_write(kop_pkg::REG_PERIOD, 32'hffff_ffff);
		apb_write(kop_pkg::REG_ECC, 32'h0000_ffff);
		apb_write(kop_pkg::REG_DISTANCE, 32'h3fff_ffff);
		apb_write(kop_pkg::REG_CENTER_X, 32'h7fff_ffff);
		apb_write(kop_pkg::REG_CENTER_Y, 32'h8000_0000);
		apb_write(kop_pkg::REG_CENTER_Z, 32'h8000_0000);
		send_step(32'h4000_0000);
		send_step(32'h4000_0000);
		send_step(32'h4000_0000);
		send_step(32'h3fff_ffff);
		send_step(32'hffff_ffff);
		finish_sending();
		apb_write(kop_pkg::REG_CENTER_X, 32'h8000_0000);
		apb_write(kop_pkg::REG_CENTER_Z, 32'h7fff_ffff);
		apb_write(kop_pkg::REG_ECC, 32'd64880);
		send_step(32'h8000_0000);
		send_step(32'h2000_0000);
		send_step(32'h0);
		finish_sending();

		// Random phases with fresh settings
		for (int ph = 0; ph < 8; ph++) begin
			per = pick_period();
			apb_write(kop_pkg::REG_PERIOD, per);
			apb_write(kop_pkg::REG_ECC,
				($urandom_range(0, 3) == 0) ? 32'h0000_ffff : $urandom);
			apb_write(kop_pkg::REG_DISTANCE,
				($urandom_range(0, 3) == 0) ? 32'h3fff_ffff : $urandom);
			apb_write(kop_pkg::REG_CENTER_X, $urandom);
			apb_write(kop_pkg::REG_CENTER_Y, $urandom);
			apb_write(kop_pkg::REG_CENTER_Z, $urandom);
			for (int k = 0; k < 100; k++) send_step(pick_delta(per));
			finish_sending();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_pos.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
